FILE: src/pcp_pkg.sv
// Shared constants, register codes and payload types of the point camera projection unit.
package pcp_pkg;

	localparam int COORD_W        = 20;
	localparam int AXIS_FRAC_BITS = 14;
	localparam int AXIS_COMP_W    = 16;
	localparam int AXIS_W         = 3 * AXIS_COMP_W;
	localparam int ORIGIN_W       = 3 * COORD_W;
	localparam int FOCAL_W        = 19;
	localparam int CFG_DATA_W     = (ORIGIN_W > AXIS_W) ? ORIGIN_W : AXIS_W;
	localparam int CFG_INDEX_W    = 3;

	// Magnitude of coordinate times focal length, and the divider built around it.
	localparam int NUM_W      = COORD_W + FOCAL_W - 1;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int QUO_W      = DIV_STAGES * DIV_STEPS;

	localparam logic [FOCAL_W-1:0] FOCAL_RESET = FOCAL_W'(256);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_ORIGIN = CFG_INDEX_W'(0),
		REG_AXIS_RIGHT   = CFG_INDEX_W'(1),
		REG_AXIS_UP      = CFG_INDEX_W'(2),
		REG_AXIS_DEPTH   = CFG_INDEX_W'(3),
		REG_FOCAL_LENGTH = CFG_INDEX_W'(4)
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} pcp_point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cam_x;
		logic signed [COORD_W-1:0] cam_y;
		logic signed [COORD_W-1:0] cam_z;
		logic signed [COORD_W-1:0] screen_x;
		logic signed [COORD_W-1:0] screen_y;
		logic                      depth_zero;
		logic                      saturated;
	} pcp_result_t;

	typedef struct packed {
		logic                      valid;
		logic signed [COORD_W-1:0] cam_x;
		logic signed [COORD_W-1:0] cam_y;
		logic signed [COORD_W-1:0] cam_z;
		logic                      clamped;
	} pcp_cam_t;

endpackage

FILE: src/point_camera_projection_unit.sv
// Top level of the point camera projection unit: registers, pipeline and output buffer.
//
// Channel   Signals                                   Moves
// point     point_valid, point_ready, point           one 3D point per transaction
// result    result_valid, result_ready, result        camera and screen coordinates
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data one register write per transaction
//
// One point is taken every cycle while point_ready is high; its result passes the transform,
// the focal multiply, the 19 divider stages (two quotient bits each) and the output register.
// Reset clears the pipeline valid bits and the output buffer and loads the default frame.
// The whole pipeline holds while its two-entry output buffer is full, so nothing is lost.
module point_camera_projection_unit #(
	parameter int AXIS_FRAC_BITS = pcp_pkg::AXIS_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               point_valid,
	output logic                               point_ready,
	input  pcp_pkg::pcp_point_t                point,
	output logic                               result_valid,
	input  logic                               result_ready,
	output pcp_pkg::pcp_result_t               result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pcp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int ACW = pcp_pkg::AXIS_COMP_W;
	localparam logic [ACW-1:0] AXIS_ONE = ACW'(1) << AXIS_FRAC_BITS;

	logic [pcp_pkg::ORIGIN_W-1:0] frame_origin_q;
	logic [pcp_pkg::AXIS_W-1:0]   axis_right_q, axis_up_q, axis_depth_q;
	logic [pcp_pkg::FOCAL_W-1:0]  focal_length_q;

	logic                  en;
	pcp_pkg::pcp_cam_t     cam;
	logic                  proj_valid;
	pcp_pkg::pcp_result_t  proj_result;
	logic                  push, pop;
	logic [1:0]            cnt_q;
	logic                  wr_ptr_q, rd_ptr_q;
	pcp_pkg::pcp_result_t  obuf_q [2];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_origin_q <= '0;
			axis_right_q   <= {{(2*ACW){1'b0}}, AXIS_ONE};
			axis_up_q      <= {{ACW{1'b0}}, AXIS_ONE, {ACW{1'b0}}};
			axis_depth_q   <= {AXIS_ONE, {(2*ACW){1'b0}}};
			focal_length_q <= pcp_pkg::FOCAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pcp_pkg::cfg_reg_t'(cfg_index))
				pcp_pkg::REG_FRAME_ORIGIN: frame_origin_q <= cfg_data[pcp_pkg::ORIGIN_W-1:0];
				pcp_pkg::REG_AXIS_RIGHT:   axis_right_q   <= cfg_data[pcp_pkg::AXIS_W-1:0];
				pcp_pkg::REG_AXIS_UP:      axis_up_q      <= cfg_data[pcp_pkg::AXIS_W-1:0];
				pcp_pkg::REG_AXIS_DEPTH:   axis_depth_q   <= cfg_data[pcp_pkg::AXIS_W-1:0];
				pcp_pkg::REG_FOCAL_LENGTH: focal_length_q <= cfg_data[pcp_pkg::FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign en          = (cnt_q != 2'd2);
	assign point_ready = en;

	pcp_transform #(
		.AXIS_FRAC_BITS (AXIS_FRAC_BITS)
	) u_transform (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.point_valid  (point_valid),
		.point        (point),
		.frame_origin (frame_origin_q),
		.axis_right   (axis_right_q),
		.axis_up      (axis_up_q),
		.axis_depth   (axis_depth_q),
		.cam          (cam)
	);

	pcp_project u_project (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cam          (cam),
		.focal_length (focal_length_q),
		.res_valid    (proj_valid),
		.res          (proj_result)
	);

	assign push = en && proj_valid;
	assign pop  = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			obuf_q[wr_ptr_q] <= proj_result;
		end
	end

	assign result_valid = (cnt_q != 2'd0);
	assign result       = obuf_q[rd_ptr_q];

endmodule

FILE: src/pcp_transform.sv
// Origin subtraction, dot products with the frame axes and saturation, in four pipeline stages.
module pcp_transform #(
	parameter int AXIS_FRAC_BITS = pcp_pkg::AXIS_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          point_valid,
	input  pcp_pkg::pcp_point_t           point,
	input  logic [pcp_pkg::ORIGIN_W-1:0]  frame_origin,
	input  logic [pcp_pkg::AXIS_W-1:0]    axis_right,
	input  logic [pcp_pkg::AXIS_W-1:0]    axis_up,
	input  logic [pcp_pkg::AXIS_W-1:0]    axis_depth,
	output pcp_pkg::pcp_cam_t             cam
);

	localparam int CW     = pcp_pkg::COORD_W;
	localparam int ACW    = pcp_pkg::AXIS_COMP_W;
	localparam int PROD_W = CW + 1 + ACW;
	localparam int ACC_W  = (((CW + ACW + 3) > (AXIS_FRAC_BITS + 1)) ?
		(CW + ACW + 3) : (AXIS_FRAC_BITS + 1)) + 1;
	localparam logic signed [ACC_W-1:0] ROUND =
		{{(ACC_W-1){1'b0}}, 1'b1} << (AXIS_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

	logic signed [CW-1:0]     pt [3];
	logic [pcp_pkg::AXIS_W-1:0] axis [3];
	logic signed [CW:0]       d_c [3];
	logic signed [PROD_W-1:0] prod_c [3][3];
	logic signed [ACC_W-1:0]  sum_c [3];
	logic signed [CW-1:0]     cam_c [3];
	logic [2:0]               clamp_c;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [CW:0]       d_s1 [3];
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic signed [ACC_W-1:0]  sum_s3 [3];
	logic signed [CW-1:0]     cam_s4 [3];
	logic                     clamped_s4;

	assign pt[0]   = point.point_x;
	assign pt[1]   = point.point_y;
	assign pt[2]   = point.point_z;
	assign axis[0] = axis_right;
	assign axis[1] = axis_up;
	assign axis[2] = axis_depth;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = $signed({pt[i][CW-1], pt[i]})
				- $signed({frame_origin[i*CW+CW-1], frame_origin[i*CW +: CW]});
		end
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				prod_c[j][i] = PROD_W'(d_s1[i]) * PROD_W'($signed(axis[j][i*ACW +: ACW]));
			end
			sum_c[j] = ACC_W'(prod_s2[j][0]) + ACC_W'(prod_s2[j][1])
				+ ACC_W'(prod_s2[j][2]) + ROUND;
		end
		for (int j = 0; j < 3; j++) begin
			if ((sum_s3[j] >>> AXIS_FRAC_BITS) > SAT_HI) begin
				cam_c[j]   = SAT_HI[CW-1:0];
				clamp_c[j] = 1'b1;
			end else if ((sum_s3[j] >>> AXIS_FRAC_BITS) < SAT_LO) begin
				cam_c[j]   = SAT_LO[CW-1:0];
				clamp_c[j] = 1'b1;
			end else begin
				cam_c[j]   = CW'(sum_s3[j] >>> AXIS_FRAC_BITS);
				clamp_c[j] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= point_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1       <= d_c;
			prod_s2    <= prod_c;
			sum_s3     <= sum_c;
			cam_s4     <= cam_c;
			clamped_s4 <= |clamp_c;
		end
	end

	assign cam.valid   = vld_s4;
	assign cam.cam_x   = cam_s4[0];
	assign cam.cam_y   = cam_s4[1];
	assign cam.cam_z   = cam_s4[2];
	assign cam.clamped = clamped_s4;

endmodule

FILE: src/pcp_div.sv
// Pipelined restoring divider for unsigned magnitudes, two quotient bits per stage.
module pcp_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [pcp_pkg::QUO_W-1:0]    dividend,
	input  logic [pcp_pkg::COORD_W-1:0]  divisor,
	output logic [pcp_pkg::QUO_W-1:0]    quotient
);

	localparam int CW  = pcp_pkg::COORD_W;
	localparam int QW  = pcp_pkg::QUO_W;
	localparam int NST = pcp_pkg::DIV_STAGES;

	logic [CW-1:0] rem_s [NST];
	logic [QW-1:0] num_s [NST];
	logic [QW-1:0] quo_s [NST];
	logic [CW-1:0] dvs_s [NST];

	logic [CW-1:0] rem_nx [NST];
	logic [QW-1:0] num_nx [NST];
	logic [QW-1:0] quo_nx [NST];
	logic [CW-1:0] dvs_nx [NST];

	always_comb begin
		logic [CW:0]   trial;
		logic [CW-1:0] r;
		logic [CW-1:0] d;
		logic [QW-1:0] n;
		logic [QW-1:0] q;
		for (int g = 0; g < NST; g++) begin
			if (g == 0) begin
				r = '0;
				n = dividend;
				q = '0;
				d = divisor;
			end else begin
				r = rem_s[g-1];
				n = num_s[g-1];
				q = quo_s[g-1];
				d = dvs_s[g-1];
			end
			for (int k = 0; k < pcp_pkg::DIV_STEPS; k++) begin
				trial = {r, n[QW-1]};
				n     = {n[QW-2:0], 1'b0};
				if (trial >= {1'b0, d}) begin
					r = CW'(trial - {1'b0, d});
					q = {q[QW-2:0], 1'b1};
				end else begin
					r = trial[CW-1:0];
					q = {q[QW-2:0], 1'b0};
				end
			end
			rem_nx[g] = r;
			num_nx[g] = n;
			quo_nx[g] = q;
			dvs_nx[g] = d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_nx;
			num_s <= num_nx;
			quo_s <= quo_nx;
			dvs_s <= dvs_nx;
		end
	end

	assign quotient = quo_s[NST-1];

endmodule

FILE: src/pcp_project.sv
// Perspective divide: focal multiply, sign split, pipelined division and output clamping.
module pcp_project (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  pcp_pkg::pcp_cam_t             cam,
	input  logic [pcp_pkg::FOCAL_W-1:0]   focal_length,
	output logic                          res_valid,
	output pcp_pkg::pcp_result_t          res
);

	localparam int CW     = pcp_pkg::COORD_W;
	localparam int QW     = pcp_pkg::QUO_W;
	localparam int NST    = pcp_pkg::DIV_STAGES;
	localparam int NUMS_W = CW + pcp_pkg::FOCAL_W;
	localparam logic [QW-1:0] Q_POS_MAX = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic [QW-1:0] Q_NEG_MAX = {{(QW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0] cam_x;
		logic signed [CW-1:0] cam_y;
		logic signed [CW-1:0] cam_z;
		logic                 zero;
		logic                 clamped;
		logic                 neg_x;
		logic                 neg_y;
	} side_t;

	function automatic logic [CW:0] clamp_quo(input logic [QW-1:0] q, input logic neg);
		logic [CW-1:0] mag;
		mag = q[CW-1:0];
		if (!neg && q > Q_POS_MAX) begin
			return {1'b1, Q_POS_MAX[CW-1:0]};
		end else if (neg && q > Q_NEG_MAX) begin
			return {1'b1, Q_NEG_MAX[CW-1:0]};
		end else if (neg) begin
			return {1'b0, CW'(-mag)};
		end
		return {1'b0, mag};
	endfunction

	logic signed [NUMS_W-1:0] num_x_c, num_y_c, abs_x_c, abs_y_c;
	logic signed [CW:0]       abs_z_c;
	side_t                    side_c;
	logic [CW:0]              lane_x_c, lane_y_c;
	pcp_pkg::pcp_result_t     res_c;

	logic                     vld_s5, vld_s6;
	logic signed [NUMS_W-1:0] num_x_s5, num_y_s5;
	side_t                    side_s5, side_s6;
	logic [QW-1:0]            mag_x_s6, mag_y_s6;
	logic [CW-1:0]            mag_z_s6;
	logic                     div_vld_s [NST];
	side_t                    div_side_s [NST];
	logic [QW-1:0]            quo_x, quo_y;
	logic                     vld_sn;
	pcp_pkg::pcp_result_t     res_sn;

	always_comb begin
		num_x_c = NUMS_W'(cam.cam_x) * NUMS_W'($signed({1'b0, focal_length}));
		num_y_c = NUMS_W'(cam.cam_y) * NUMS_W'($signed({1'b0, focal_length}));

		abs_x_c = num_x_s5[NUMS_W-1] ? -num_x_s5 : num_x_s5;
		abs_y_c = num_y_s5[NUMS_W-1] ? -num_y_s5 : num_y_s5;
		abs_z_c = side_s5.cam_z[CW-1] ? -(CW+1)'(side_s5.cam_z) : (CW+1)'(side_s5.cam_z);

		side_c       = side_s5;
		side_c.neg_x = num_x_s5[NUMS_W-1] ^ side_s5.cam_z[CW-1];
		side_c.neg_y = num_y_s5[NUMS_W-1] ^ side_s5.cam_z[CW-1];

		lane_x_c = clamp_quo(quo_x, div_side_s[NST-1].neg_x);
		lane_y_c = clamp_quo(quo_y, div_side_s[NST-1].neg_y);

		res_c.cam_x      = div_side_s[NST-1].cam_x;
		res_c.cam_y      = div_side_s[NST-1].cam_y;
		res_c.cam_z      = div_side_s[NST-1].cam_z;
		res_c.depth_zero = div_side_s[NST-1].zero;
		if (div_side_s[NST-1].zero) begin
			res_c.screen_x  = '0;
			res_c.screen_y  = '0;
			res_c.saturated = div_side_s[NST-1].clamped;
		end else begin
			res_c.screen_x  = lane_x_c[CW-1:0];
			res_c.screen_y  = lane_y_c[CW-1:0];
			res_c.saturated = div_side_s[NST-1].clamped | lane_x_c[CW] | lane_y_c[CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int g = 0; g < NST; g++) begin
				div_vld_s[g] <= 1'b0;
			end
			vld_sn <= 1'b0;
		end else if (en) begin
			vld_s5       <= cam.valid;
			vld_s6       <= vld_s5;
			div_vld_s[0] <= vld_s6;
			for (int g = 1; g < NST; g++) begin
				div_vld_s[g] <= div_vld_s[g-1];
			end
			vld_sn <= div_vld_s[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s5        <= num_x_c;
			num_y_s5        <= num_y_c;
			side_s5.cam_x   <= cam.cam_x;
			side_s5.cam_y   <= cam.cam_y;
			side_s5.cam_z   <= cam.cam_z;
			side_s5.zero    <= (cam.cam_z == '0);
			side_s5.clamped <= cam.clamped;
			side_s5.neg_x   <= 1'b0;
			side_s5.neg_y   <= 1'b0;
			side_s6         <= side_c;
			mag_x_s6        <= QW'(abs_x_c[pcp_pkg::NUM_W-1:0]);
			mag_y_s6        <= QW'(abs_y_c[pcp_pkg::NUM_W-1:0]);
			mag_z_s6        <= abs_z_c[CW-1:0];
			div_side_s[0]   <= side_s6;
			for (int g = 1; g < NST; g++) begin
				div_side_s[g] <= div_side_s[g-1];
			end
			res_sn <= res_c;
		end
	end

	pcp_div u_div_x (
		.clk      (clk),
		.en       (en),
		.dividend (mag_x_s6),
		.divisor  (mag_z_s6),
		.quotient (quo_x)
	);

	pcp_div u_div_y (
		.clk      (clk),
		.en       (en),
		.dividend (mag_y_s6),
		.divisor  (mag_z_s6),
		.quotient (quo_y)
	);

	assign res_valid = vld_sn;
	assign res       = res_sn;

endmodule
